/* rtl/terrain_cut_fill_volume_defines.svh */
// ----------------------------------------------------------------------------
// Terrain cut/fill volume: assertion macros
// Shorthand for clocked assertions with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_CUT_FILL_VOLUME_DEFINES_SVH
`define TERRAIN_CUT_FILL_VOLUME_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define TCFV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent in the next cycle
`define TCFV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcfv_pkg.sv */
// ----------------------------------------------------------------------------
// Terrain cut/fill volume package
// Widths, register indexes, sequencer types and small helpers.
// ----------------------------------------------------------------------------
package tcfv_pkg;

  localparam int LIMB_W  = 34;            // multiplier operand width
  localparam int PROD_W  = 2 * LIMB_W;    // product and two-limb operand width
  localparam int CR_W    = 68;            // signed cross product
  localparam int D_W     = 67;            // twice the area, magnitude
  localparam int SUM_W   = 66;            // a*x + b*y + rounding
  localparam int DZ_W    = 51;            // height above plane
  localparam int POS_W   = 52;            // positive or negative height sum
  localparam int TOT_W   = 53;            // pos + neg, divider remainder
  localparam int Q_W     = 52;            // divider quotient
  localparam int NUM_W   = Q_W + TOT_W;   // divider dividend
  localparam int ACC_W   = 2 * PROD_W;    // multi-limb product accumulator
  localparam int D6_W    = 120;           // dividend of the divide by six
  localparam int D6_STEP = 8;             // bits per cycle of the divide by six
  localparam int D6_CYC  = D6_W / D6_STEP;
  localparam int TOTAL_W = 63;
  localparam int IN_W    = 288;
  localparam int OUT_W   = 256;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [TOTAL_W-1:0] MAX63 = {TOTAL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CR_A, ST_CR_B, ST_CR_C, ST_ABS,
    ST_PX, ST_PY, ST_SUMH, ST_DZ, ST_ACCUM, ST_TOTAL,
    ST_MUL, ST_MADD, ST_DIVGO, ST_DIV, ST_D6, ST_ADD,
    ST_FIN, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_QP, PH_QN, PH_CUT, PH_FILL} phase_t;

  // magnitude of a 33-bit two's complement value
  function automatic logic [LIMB_W-1:0] mag33(input logic [32:0] v);
    logic [32:0] m;
    m = v[32] ? (~v + 33'd1) : v;
    return {1'b0, m};
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add63(input logic [TOTAL_W-1:0] a,
                                                    input logic [TOTAL_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOTAL_W] ? MAX63 : s[TOTAL_W-1:0];
  endfunction

endpackage

/* rtl/tcfv_mul.sv */
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned limb by limb product with a registered result.
// ----------------------------------------------------------------------------
module tcfv_mul import tcfv_pkg::*; (
  input  logic              clk,
  input  logic [LIMB_W-1:0] a,
  input  logic [LIMB_W-1:0] b,
  output logic [PROD_W-1:0] p
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

/* rtl/tcfv_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle; quotient known below 2^Q_W.
// ----------------------------------------------------------------------------
module tcfv_div import tcfv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [TOT_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             done
);

  localparam int CNT_W = $clog2(Q_W);

  logic [TOT_W-1:0] rem_r;
  logic [Q_W-1:0]   nsh_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [TOT_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, nsh_r[Q_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:Q_W];
      nsh_r <= num[Q_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? TOT_W'(trial - {1'b0, den}) : TOT_W'(trial);
      nsh_r <= {nsh_r[Q_W-2:0], ge};
    end
  end

  assign quo  = nsh_r;
  assign done = done_r;

endmodule

/* rtl/terrain_cut_fill_volume.sv */
// ----------------------------------------------------------------------------
// Terrain cut/fill volume against a design plane
// Accumulates cut, fill and projected area over a stream of triangles.
// ----------------------------------------------------------------------------
// One triangle is taken at a time. A degenerate triangle ends after the area
// check, a flat one after the height sums, and one with volume runs four
// two-limb products on the shared 34x34 multiplier, two bit-serial divisions
// with 52-bit quotients for the squared height shares, and two divides by six.
// A triangle marked last adds a result item carrying the totals, which then
// restart from zero; the next triangle may be accepted while that result waits.
`include "terrain_cut_fill_volume_defines.svh"

module terrain_cut_fill_volume import tcfv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2 (32 bits each)
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // cut_total[62:0], fill_total[125:63], net_total[189:126], area_total[252:190]
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic signed [31:0] slope_x_r, slope_y_r, offset_r;
  logic signed [31:0] vx_r [3];
  logic signed [31:0] vy_r [3];
  logic signed [31:0] vz_r [3];
  logic               last_r;

  logic signed [CR_W-1:0]  cr_r;
  logic [D_W-1:0]          d_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [DZ_W-1:0]  dz_r;
  logic [POS_W-1:0]        pos_r, neg_r;
  logic [TOT_W-1:0]        tot_r;
  logic [1:0]              k_r, lc_r;
  logic [PROD_W-1:0]       ma_r, mb_r;
  logic [ACC_W-1:0]        acc_r;
  logic [Q_W-1:0]          qp_r, qn_r;
  logic [D6_W-1:0]         d6_r;
  logic [2:0]              rem6_r;
  logic [3:0]              cnt6_r;
  logic                    sgn_r, sgn_nxt;
  logic [TOTAL_W-1:0]      cut_r, fill_r, area_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  logic [LIMB_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]       prod;
  logic signed [CR_W-1:0]  pterm;
  logic signed [32:0]      dx1, dy2, dx2, dy1;
  logic [D_W-1:0]          dabs;
  logic [D_W-2:0]          half;
  logic [TOTAL_W-1:0]      half_sat, vol_sat;
  logic signed [DZ_W-1:0]  dz_calc;
  logic [TOT_W-1:0]        tot_calc;
  logic [ACC_W-1:0]        acc_sum, acc_term;
  logic [D6_STEP-1:0]      q6;
  logic [2:0]              r6;
  logic                    div_start, div_done;
  logic [Q_W-1:0]          div_quo;
  logic                    in_acc, emit_go;
  logic signed [63:0]      net;

  tcfv_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  tcfv_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(acc_r[NUM_W-1:0]),
    .den(tot_r), .quo(div_quo), .done(div_done)
  );

  assign dx1 = 33'(vx_r[1]) - 33'(vx_r[0]);
  assign dy2 = 33'(vy_r[2]) - 33'(vy_r[0]);
  assign dx2 = 33'(vx_r[2]) - 33'(vx_r[0]);
  assign dy1 = 33'(vy_r[1]) - 33'(vy_r[0]);

  assign pterm = sgn_r ? -$signed(prod) : $signed(prod);

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sgn_nxt = 1'b0;
    case (state_r)
      ST_CR_A: begin
        mul_a = mag33(dx1); mul_b = mag33(dy2); sgn_nxt = dx1[32] ^ dy2[32];
      end
      ST_CR_B: begin
        mul_a = mag33(dx2); mul_b = mag33(dy1); sgn_nxt = dx2[32] ^ dy1[32];
      end
      ST_PX: begin
        mul_a   = mag33(33'(slope_x_r));
        mul_b   = mag33(33'(vx_r[k_r]));
        sgn_nxt = slope_x_r[31] ^ vx_r[k_r][31];
      end
      ST_PY: begin
        mul_a   = mag33(33'(slope_y_r));
        mul_b   = mag33(33'(vy_r[k_r]));
        sgn_nxt = slope_y_r[31] ^ vy_r[k_r][31];
      end
      ST_MUL: begin
        mul_a = lc_r[1] ? ma_r[PROD_W-1:LIMB_W] : ma_r[LIMB_W-1:0];
        mul_b = lc_r[0] ? mb_r[PROD_W-1:LIMB_W] : mb_r[LIMB_W-1:0];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign dabs     = cr_r[CR_W-1] ? D_W'(-cr_r) : D_W'(cr_r);
  assign half     = dabs[D_W-1:1];
  assign half_sat = (|half[D_W-2:TOTAL_W]) ? MAX63 : half[TOTAL_W-1:0];
  assign dz_calc  = DZ_W'(vz_r[k_r]) - DZ_W'(sum_r >>> 16) - DZ_W'(offset_r);
  assign tot_calc = TOT_W'(pos_r) + TOT_W'(neg_r);
  assign vol_sat  = (|d6_r[D6_W-1:TOTAL_W]) ? MAX63 : d6_r[TOTAL_W-1:0];
  assign net      = $signed({1'b0, cut_r}) - $signed({1'b0, fill_r});

  always_comb begin
    case (lc_r)
      2'd0:    acc_term = ACC_W'(prod);
      2'd3:    acc_term = ACC_W'(prod) << (2 * LIMB_W);
      default: acc_term = ACC_W'(prod) << LIMB_W;
    endcase
  end
  assign acc_sum = acc_r + acc_term;

  // eight steps of long division by six
  always_comb begin
    logic [3:0] t;
    r6 = rem6_r;
    q6 = '0;
    for (int i = 0; i < D6_STEP; i++) begin
      t = {r6, d6_r[D6_W-1-i]};
      if (t >= 4'd6) begin
        q6[D6_STEP-1-i] = 1'b1;
        r6 = 3'(t - 4'd6);
      end else begin
        r6 = t[2:0];
      end
    end
  end

  assign in_acc    = in_tvalid && in_tready;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign div_start = (state_r == ST_DIVGO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_CR_A;
      end
      ST_CR_A: state_nxt = ST_CR_B;
      ST_CR_B: state_nxt = ST_CR_C;
      ST_CR_C: state_nxt = ST_ABS;
      ST_ABS:  state_nxt = (dabs == '0) ? ST_FIN : ST_PX;
      ST_PX:   state_nxt = ST_PY;
      ST_PY:   state_nxt = ST_SUMH;
      ST_SUMH: state_nxt = ST_DZ;
      ST_DZ:   state_nxt = ST_ACCUM;
      ST_ACCUM: state_nxt = (k_r == 2'd2) ? ST_TOTAL : ST_PX;
      ST_TOTAL: state_nxt = (tot_calc == '0) ? ST_FIN : ST_MUL;
      ST_MUL:  state_nxt = ST_MADD;
      ST_MADD: begin
        if (lc_r != 2'd3) state_nxt = ST_MUL;
        else if (phase_r == PH_QP || phase_r == PH_QN) state_nxt = ST_DIVGO;
        else state_nxt = ST_D6;
      end
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      ST_D6:   if (cnt6_r == 4'(D6_CYC - 1)) state_nxt = ST_ADD;
      ST_ADD:  state_nxt = (phase_r == PH_CUT) ? ST_MUL : ST_FIN;
      ST_FIN:  state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (emit_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration and running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_x_r   <= '0;
      slope_y_r   <= '0;
      offset_r    <= '0;
      cut_r       <= '0;
      fill_r      <= '0;
      area_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOPE_X: slope_x_r <= cfg_wdata;
          CFG_SLOPE_Y: slope_y_r <= cfg_wdata;
          CFG_OFFSET:  offset_r  <= cfg_wdata;
          default:     ;
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (state_r == ST_ABS && dabs != '0) area_r <= sat_add63(area_r, half_sat);
      if (state_r == ST_ADD) begin
        if (phase_r == PH_CUT) cut_r <= sat_add63(cut_r, vol_sat);
        else fill_r <= sat_add63(fill_r, vol_sat);
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
        cut_r       <= '0;
        fill_r      <= '0;
        area_r      <= '0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    sgn_r <= sgn_nxt;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int v = 0; v < 3; v++) begin
            vx_r[v] <= in_tdata[96*v      +: 32];
            vy_r[v] <= in_tdata[96*v + 32 +: 32];
            vz_r[v] <= in_tdata[96*v + 64 +: 32];
          end
          last_r <= in_tlast;
        end
      end
      ST_CR_B: cr_r <= pterm;
      ST_CR_C: cr_r <= cr_r - pterm;
      ST_ABS: begin
        d_r   <= dabs;
        pos_r <= '0;
        neg_r <= '0;
        k_r   <= '0;
      end
      ST_PY:   sum_r <= SUM_W'(pterm);
      ST_SUMH: sum_r <= sum_r + SUM_W'(pterm) + SUM_W'(32768);
      ST_DZ:   dz_r  <= dz_calc;
      ST_ACCUM: begin
        if (!dz_r[DZ_W-1] && dz_r != '0) pos_r <= pos_r + POS_W'(dz_r);
        else neg_r <= neg_r + POS_W'(-dz_r);
        k_r <= k_r + 2'd1;
      end
      ST_TOTAL: begin
        tot_r   <= tot_calc;
        ma_r    <= PROD_W'(pos_r);
        mb_r    <= PROD_W'(pos_r);
        acc_r   <= '0;
        lc_r    <= '0;
        phase_r <= PH_QP;
      end
      ST_MADD: begin
        acc_r  <= acc_sum;
        lc_r   <= lc_r + 2'd1;
        d6_r   <= acc_sum[D6_W-1:0];
        rem6_r <= '0;
        cnt6_r <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          acc_r <= '0;
          lc_r  <= '0;
          if (phase_r == PH_QP) begin
            qp_r    <= div_quo;
            ma_r    <= PROD_W'(neg_r);
            mb_r    <= PROD_W'(neg_r);
            phase_r <= PH_QN;
          end else begin
            qn_r    <= div_quo;
            ma_r    <= PROD_W'(d_r);
            mb_r    <= PROD_W'(qp_r);
            phase_r <= PH_CUT;
          end
        end
      end
      ST_D6: begin
        d6_r   <= {d6_r[D6_W-D6_STEP-1:0], q6};
        rem6_r <= r6;
        cnt6_r <= cnt6_r + 4'd1;
      end
      ST_ADD: begin
        if (phase_r == PH_CUT) begin
          ma_r    <= PROD_W'(d_r);
          mb_r    <= PROD_W'(qn_r);
          acc_r   <= '0;
          lc_r    <= '0;
          phase_r <= PH_FILL;
        end
      end
      ST_EMIT: begin
        if (emit_go) out_data_r <= {3'b000, area_r, net, fill_r, cut_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `TCFV_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r == ST_CR_A,
                    "accepted item did not start the cross product")
  `TCFV_ASSERT_SAME(a_div_done_in_wait, div_done, state_r == ST_DIV,
                    "divider finished outside its wait state")
  `TCFV_ASSERT_NEXT(a_area_monotonic, state_r != ST_EMIT, area_r >= $past(area_r),
                    "area total decreased without an emit")
  `TCFV_ASSERT_NEXT(a_degenerate_skip, state_r == ST_ABS && cr_r == '0,
                    state_r == ST_FIN, "zero-area triangle was not skipped")

endmodule
